[sv/clipped_rect_line_fill_engine_top_assert.svh]
// Assertion macros for the clipped rectangle and line fill engine.
// Included by the top level; needs no package.
`ifndef CLIPPED_RECT_LINE_FILL_ENGINE_TOP_ASSERT_SVH
`define CLIPPED_RECT_LINE_FILL_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, ignored while reset is asserted.
`define CRLFE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds through reset.
`define CRLFE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRLFE_ASSERT(label, clk, rstn, prop, msg)
`define CRLFE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[sv/crlfe_pkg.sv]
// Types, constants and the microcode table of the fill engine.
// Used by crlfe_dp and the top level; depends on nothing.
package crlfe_pkg;

    localparam int OPCODE_W   = 3;
    localparam int COORD_IN_W = 12;
    localparam int EXTENT_W   = 11;
    localparam int COLOR_W    = 16;
    localparam int COORD_W    = 13;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 16;
    localparam int STEP_W     = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [STEP_W-1:0]         step_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ        = 3'd0,
        OP_PIXEL       = 3'd1,
        OP_HSPAN       = 3'd2,
        OP_VSPAN       = 3'd3,
        OP_RECT        = 3'd4,
        OP_FILL_RECT   = 3'd5,
        OP_FILL_SCREEN = 3'd6
    } opcode_e;

    typedef enum logic [2:0] {
        UOP_DISPATCH,
        UOP_LOAD,
        UOP_BASE,
        UOP_DRAW,
        UOP_RDREQ,
        UOP_EMIT,
        UOP_GOTO
    } uop_e;

    typedef enum logic [3:0] {
        BOX_POINT,
        BOX_HSPAN,
        BOX_VSPAN,
        BOX_TOP,
        BOX_BOTTOM,
        BOX_LEFT,
        BOX_RIGHT,
        BOX_FILL,
        BOX_SCREEN
    } box_sel_e;

    typedef struct packed {
        uop_e     uop;
        box_sel_e box_sel;
        step_t    target;
    } ucode_t;

    typedef struct packed {
        uop_e     uop;
        box_sel_e box_sel;
        logic     cmd_load;
    } dp_ctrl_t;

    typedef struct packed {
        logic box_empty;
        logic draw_last;
    } dp_stat_t;

    // Program labels
    localparam step_t L_DISPATCH   = 6'd0;
    localparam step_t L_READ       = 6'd1;
    localparam step_t L_READ_EMIT  = 6'd4;
    localparam step_t L_PIXEL      = 6'd6;
    localparam step_t L_HSPAN      = 6'd10;
    localparam step_t L_VSPAN      = 6'd14;
    localparam step_t L_RECT       = 6'd18;
    localparam step_t L_RECT_BOT   = 6'd21;
    localparam step_t L_RECT_LEFT  = 6'd24;
    localparam step_t L_RECT_RIGHT = 6'd27;
    localparam step_t L_FILL       = 6'd31;
    localparam step_t L_SCREEN     = 6'd35;
    localparam step_t LAST_STEP    = 6'd38;

    function automatic ucode_t uw(uop_e op, box_sel_e sel, step_t tgt);
        ucode_t w;
        w.uop     = op;
        w.box_sel = sel;
        w.target  = tgt;
        return w;
    endfunction

    // Each drawing box is LOAD (clip, skip if empty), BASE (row address), DRAW (loop); a read does RDREQ, then EMIT.
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        w = uw(UOP_GOTO, BOX_POINT, L_DISPATCH);
        case (step)
            L_DISPATCH:          w = uw(UOP_DISPATCH, BOX_POINT, L_DISPATCH);
            L_READ:              w = uw(UOP_LOAD, BOX_POINT, L_READ_EMIT);
            L_READ + 6'd1:       w = uw(UOP_BASE, BOX_POINT, L_DISPATCH);
            L_READ + 6'd2:       w = uw(UOP_RDREQ, BOX_POINT, L_DISPATCH);
            L_READ_EMIT:         w = uw(UOP_EMIT, BOX_POINT, L_DISPATCH);
            L_PIXEL:             w = uw(UOP_LOAD, BOX_POINT, L_DISPATCH);
            L_PIXEL + 6'd1:      w = uw(UOP_BASE, BOX_POINT, L_DISPATCH);
            L_PIXEL + 6'd2:      w = uw(UOP_DRAW, BOX_POINT, L_DISPATCH);
            L_HSPAN:             w = uw(UOP_LOAD, BOX_HSPAN, L_DISPATCH);
            L_HSPAN + 6'd1:      w = uw(UOP_BASE, BOX_HSPAN, L_DISPATCH);
            L_HSPAN + 6'd2:      w = uw(UOP_DRAW, BOX_HSPAN, L_DISPATCH);
            L_VSPAN:             w = uw(UOP_LOAD, BOX_VSPAN, L_DISPATCH);
            L_VSPAN + 6'd1:      w = uw(UOP_BASE, BOX_VSPAN, L_DISPATCH);
            L_VSPAN + 6'd2:      w = uw(UOP_DRAW, BOX_VSPAN, L_DISPATCH);
            L_RECT:              w = uw(UOP_LOAD, BOX_TOP, L_RECT_BOT);
            L_RECT + 6'd1:       w = uw(UOP_BASE, BOX_TOP, L_DISPATCH);
            L_RECT + 6'd2:       w = uw(UOP_DRAW, BOX_TOP, L_DISPATCH);
            L_RECT_BOT:          w = uw(UOP_LOAD, BOX_BOTTOM, L_RECT_LEFT);
            L_RECT_BOT + 6'd1:   w = uw(UOP_BASE, BOX_BOTTOM, L_DISPATCH);
            L_RECT_BOT + 6'd2:   w = uw(UOP_DRAW, BOX_BOTTOM, L_DISPATCH);
            L_RECT_LEFT:         w = uw(UOP_LOAD, BOX_LEFT, L_RECT_RIGHT);
            L_RECT_LEFT + 6'd1:  w = uw(UOP_BASE, BOX_LEFT, L_DISPATCH);
            L_RECT_LEFT + 6'd2:  w = uw(UOP_DRAW, BOX_LEFT, L_DISPATCH);
            L_RECT_RIGHT:        w = uw(UOP_LOAD, BOX_RIGHT, L_DISPATCH);
            L_RECT_RIGHT + 6'd1: w = uw(UOP_BASE, BOX_RIGHT, L_DISPATCH);
            L_RECT_RIGHT + 6'd2: w = uw(UOP_DRAW, BOX_RIGHT, L_DISPATCH);
            L_FILL:              w = uw(UOP_LOAD, BOX_FILL, L_DISPATCH);
            L_FILL + 6'd1:       w = uw(UOP_BASE, BOX_FILL, L_DISPATCH);
            L_FILL + 6'd2:       w = uw(UOP_DRAW, BOX_FILL, L_DISPATCH);
            L_SCREEN:            w = uw(UOP_LOAD, BOX_SCREEN, L_DISPATCH);
            L_SCREEN + 6'd1:     w = uw(UOP_BASE, BOX_SCREEN, L_DISPATCH);
            L_SCREEN + 6'd2:     w = uw(UOP_DRAW, BOX_SCREEN, L_DISPATCH);
            default:             w = uw(UOP_GOTO, BOX_POINT, L_DISPATCH);
        endcase
        return w;
    endfunction

    function automatic step_t entry_step(logic [OPCODE_W-1:0] op);
        step_t s;
        case (op)
            OP_READ:        s = L_READ;
            OP_PIXEL:       s = L_PIXEL;
            OP_HSPAN:       s = L_HSPAN;
            OP_VSPAN:       s = L_VSPAN;
            OP_RECT:        s = L_RECT;
            OP_FILL_RECT:   s = L_FILL;
            OP_FILL_SCREEN: s = L_SCREEN;
            default:        s = L_DISPATCH;
        endcase
        return s;
    endfunction

endpackage

[sv/crlfe_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module crlfe_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 76800,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/crlfe_dp.sv]
// Datapath of the fill engine: command registers, box clipping, raster walk
// and the frame store. Depends on crlfe_pkg and crlfe_ram.
module crlfe_dp
    import crlfe_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dp_ctrl_t                     ctrl,
    input  logic signed [COORD_IN_W-1:0] cmd_x,
    input  logic signed [COORD_IN_W-1:0] cmd_y,
    input  logic signed [COORD_IN_W-1:0] cmd_x_end,
    input  logic signed [COORD_IN_W-1:0] cmd_y_end,
    input  logic [EXTENT_W-1:0]          cmd_width,
    input  logic [EXTENT_W-1:0]          cmd_height,
    input  logic [COLOR_W-1:0]           cmd_color,
    output dp_stat_t                     stat,
    output logic [COLOR_W-1:0]           pixel_value
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam coord_t XMAX = coord_t'(SCREEN_WIDTH - 1);
    localparam coord_t YMAX = coord_t'(SCREEN_HEIGHT - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(SCREEN_WIDTH);

    coord_t x_reg, x_next, y_reg, y_next;
    coord_t xe_reg, xe_next, ye_reg, ye_next;
    coord_t xw_reg, xw_next, yh_reg, yh_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [XW-1:0] x0_reg, x0_next, x1_reg, x1_next, cx_reg, cx_next;
    logic [YW-1:0] y0_reg, y0_next, y1_reg, y1_next, cy_reg, cy_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic          empty_reg, empty_next;

    coord_t bx0, bx1, by0, by1;
    coord_t cx0, cx1, cy0, cy1;
    logic [AW-1:0]      pix_addr;
    logic [COLOR_W-1:0] rd_data;

    // Box corners for the selected edge or area, then clip to the screen.
    always_comb begin
        bx0 = '0;
        bx1 = '0;
        by0 = '0;
        by1 = '0;
        case (ctrl.box_sel)
            BOX_POINT:  begin bx0 = x_reg;  bx1 = x_reg;  by0 = y_reg;  by1 = y_reg;  end
            BOX_HSPAN:  begin bx0 = x_reg;  bx1 = xe_reg; by0 = y_reg;  by1 = y_reg;  end
            BOX_VSPAN:  begin bx0 = x_reg;  bx1 = x_reg;  by0 = y_reg;  by1 = ye_reg; end
            BOX_TOP:    begin bx0 = x_reg;  bx1 = xw_reg; by0 = y_reg;  by1 = y_reg;  end
            BOX_BOTTOM: begin bx0 = x_reg;  bx1 = xw_reg; by0 = yh_reg; by1 = yh_reg; end
            BOX_LEFT:   begin bx0 = x_reg;  bx1 = x_reg;  by0 = y_reg;  by1 = yh_reg; end
            BOX_RIGHT:  begin bx0 = xw_reg; bx1 = xw_reg; by0 = y_reg;  by1 = yh_reg; end
            BOX_FILL:   begin bx0 = x_reg;  bx1 = xw_reg; by0 = y_reg;  by1 = yh_reg; end
            BOX_SCREEN: begin bx0 = '0;     bx1 = XMAX;   by0 = '0;     by1 = YMAX;   end
            default:    begin bx0 = '0;     bx1 = '0;     by0 = '0;     by1 = '0;     end
        endcase
        cx0 = (bx0 < coord_t'(0)) ? coord_t'(0) : bx0;
        cy0 = (by0 < coord_t'(0)) ? coord_t'(0) : by0;
        cx1 = (bx1 > XMAX) ? XMAX : bx1;
        cy1 = (by1 > YMAX) ? YMAX : by1;
        stat.box_empty = (cx0 > cx1) || (cy0 > cy1);
        stat.draw_last = (cx_reg == x1_reg) && (cy_reg == y1_reg);
    end

    always_comb begin
        x_next        = x_reg;
        y_next        = y_reg;
        xe_next       = xe_reg;
        ye_next       = ye_reg;
        xw_next       = xw_reg;
        yh_next       = yh_reg;
        color_next    = color_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        row_base_next = row_base_reg;
        empty_next    = empty_reg;
        if (ctrl.cmd_load) begin
            x_next     = coord_t'(cmd_x);
            y_next     = coord_t'(cmd_y);
            xe_next    = coord_t'(cmd_x_end);
            ye_next    = coord_t'(cmd_y_end);
            xw_next    = coord_t'(cmd_x) + coord_t'({1'b0, cmd_width});
            yh_next    = coord_t'(cmd_y) + coord_t'({1'b0, cmd_height});
            color_next = cmd_color;
        end
        case (ctrl.uop)
            UOP_LOAD: begin
                x0_next    = cx0[XW-1:0];
                x1_next    = cx1[XW-1:0];
                y0_next    = cy0[YW-1:0];
                y1_next    = cy1[YW-1:0];
                empty_next = stat.box_empty;
            end
            UOP_BASE: begin
                row_base_next = AW'(y0_reg * SCREEN_WIDTH);
                cx_next       = x0_reg;
                cy_next       = y0_reg;
            end
            UOP_DRAW: begin
                if (cx_reg == x1_reg) begin
                    if (cy_reg != y1_reg) begin
                        cx_next       = x0_reg;
                        cy_next       = cy_reg + YW'(1);
                        row_base_next = row_base_reg + ROW_STEP;
                    end
                end else begin
                    cx_next = cx_reg + XW'(1);
                end
            end
            default: ;
        endcase
    end

    // Colour starts at zero so that the post-reset clearing pass paints black.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= '0;
            empty_reg <= 1'b0;
        end else begin
            color_reg <= color_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        xe_reg       <= xe_next;
        ye_reg       <= ye_next;
        xw_reg       <= xw_next;
        yh_reg       <= yh_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        row_base_reg <= row_base_next;
    end

    assign pix_addr = row_base_reg + AW'(cx_reg);

    crlfe_ram #(
        .DATA_W (COLOR_W),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .aclk    (aclk),
        .wr_en   (ctrl.uop == UOP_DRAW),
        .wr_addr (pix_addr),
        .wr_data (color_reg),
        .rd_en   (ctrl.uop == UOP_RDREQ),
        .rd_addr (pix_addr),
        .rd_data (rd_data)
    );

    assign pixel_value = empty_reg ? '0 : rd_data;

endmodule

[sv/clipped_rect_line_fill_engine_top.sv]
// Reads: a read passes the clip, row base, RAM read and emit steps, or goes from clip
//   straight to emit when it falls off screen; emit waits while the result register is full.
// Throughput: one pixel per cycle from one frame-store write port.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all
//   SCREEN_WIDTH*SCREEN_HEIGHT pixels with s_tready low.
`include "clipped_rect_line_fill_engine_top_assert.svh"

module clipped_rect_line_fill_engine_top
    import crlfe_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Command channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // x[11:0], y[23:12], x_end[35:24], y_end[47:36], width[58:48],
    // height[69:59], color[85:70], zero pad[87:86]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[2:0]
    input  logic [OPCODE_W-1:0]  s_tuser,
    // Read result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_value[15:0]
    output logic [M_TDATA_W-1:0] m_tdata
);

    step_t    step_reg, step_next;
    ucode_t   uword;
    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic     out_free;
    logic     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [COLOR_W-1:0]   pixel_value;

    // Fetch the control word of the current step.
    assign uword = ucode_rom(step_reg);

    // The output register is free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: advance, loop, or jump on a command, on datapath status or unconditionally.
    always_comb begin
        step_next = step_reg + 6'd1;
        case (uword.uop)
            UOP_DISPATCH: begin
                // Hold until a command transaction; an unused opcode is dropped.
                step_next = s_tvalid ? entry_step(s_tuser) : step_reg;
            end
            UOP_LOAD: begin
                // Skip the box entirely when clipping leaves nothing.
                if (stat.box_empty) begin
                    step_next = uword.target;
                end
            end
            UOP_DRAW: begin
                // Stay here until the last pixel of the box is written.
                if (!stat.draw_last) begin
                    step_next = step_reg;
                end
            end
            UOP_EMIT: begin
                if (!out_free) begin
                    step_next = step_reg;
                end
            end
            UOP_GOTO: step_next = uword.target;
            default:  step_next = step_reg + 6'd1;
        endcase
    end

    // Control outputs decoded from the control word.
    always_comb begin
        ctrl.uop      = uword.uop;
        ctrl.box_sel  = uword.box_sel;
        ctrl.cmd_load = (uword.uop == UOP_DISPATCH) && s_tvalid;
        s_tready      = (uword.uop == UOP_DISPATCH);
    end

    // Result register: load on emit, clear once the transaction is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if ((uword.uop == UOP_EMIT) && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = pixel_value;
        end
    end

    // Reset lands on the fill-screen program so that the store is cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= L_SCREEN;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    crlfe_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cmd_x       (s_tdata[11:0]),
        .cmd_y       (s_tdata[23:12]),
        .cmd_x_end   (s_tdata[35:24]),
        .cmd_y_end   (s_tdata[47:36]),
        .cmd_width   (s_tdata[58:48]),
        .cmd_height  (s_tdata[69:59]),
        .cmd_color   (s_tdata[85:70]),
        .stat        (stat),
        .pixel_value (pixel_value)
    );

    // The step counter never leaves the program.
    `CRLFE_ASSERT(a_step_in_program, aclk, aresetn, step_reg <= LAST_STEP, "step counter out of program")
    // A result only appears after an emit step.
    `CRLFE_ASSERT(a_result_from_emit, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(uword.uop == UOP_EMIT), "result without emit")
    // The raster loop holds its step until the box is finished.
    `CRLFE_ASSERT(a_draw_holds_step, aclk, aresetn, (uword.uop == UOP_DRAW && !stat.draw_last) |=> (step_reg == $past(step_reg)), "draw left early")

endmodule

[dv/clipped_rect_line_fill_engine_top_tb.sv]
// Self-checking testbench for the clipped rectangle and line fill engine.
// Depends on crlfe_pkg and clipped_rect_line_fill_engine_top; keeps its own frame store model
// and checks every read transaction on the result channel against it.
`timescale 1ns / 100ps

module clipped_rect_line_fill_engine_top_tb;
    import crlfe_pkg::*;

    localparam int SCR_W = 320;
    localparam int SCR_H = 240;
    localparam int READ_LATENCY = 4;
    // Opcode 7 has no meaning: the engine must drop it silently.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // x[11:0], y[23:12], x_end[35:24], y_end[47:36], width[58:48],
    // height[69:59], color[85:70], zero pad[87:86]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // opcode[2:0]
    logic [OPCODE_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // pixel_value[15:0]
    logic [M_TDATA_W-1:0] m_tdata;

    // Model of the frame store and the reads still owed by the engine
    logic [COLOR_W-1:0]   frame_model [SCR_W*SCR_H];
    logic [COLOR_W-1:0]   pending_pixel_reads [$];
    logic [COLOR_W-1:0]   expected_value;

    int     send_gap_pct;
    int     recv_stall_pct;
    int     cmds_accepted;
    int     reads_checked;
    int     mismatches;
    int     last_x;
    int     last_y;
    int     fills_left;
    longint pixels_modelled;
    longint cycle_count;
    longint watchdog_limit;

    always #6 aclk = ~aclk;

    clipped_rect_line_fill_engine_top #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Frame store model
    // ------------------------------------------------------------------

    // Paint an inclusive box clipped to the screen; return the pixel count written.
    function automatic int paint_clipped_box(int x0, int x1, int y0, int y1,
                                             logic [COLOR_W-1:0] c);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > SCR_W - 1) x1 = SCR_W - 1;
        if (y1 > SCR_H - 1) y1 = SCR_H - 1;
        if (x0 > x1 || y0 > y1) return 0;
        for (int r = y0; r <= y1; r++)
            for (int col = x0; col <= x1; col++)
                frame_model[r*SCR_W + col] = c;
        return (x1 - x0 + 1) * (y1 - y0 + 1);
    endfunction

    // Apply one accepted command to the model; queue the colour a read must return.
    // Returns the number of pixels the engine has to write for it.
    function automatic int apply_command(logic [OPCODE_W-1:0] op, int x, int y, int xe, int ye,
                                         int w, int h, logic [COLOR_W-1:0] c);
        int n;
        n = 0;
        case (op)
            OP_READ: begin
                if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H)
                    pending_pixel_reads.push_back(frame_model[y*SCR_W + x]);
                else
                    pending_pixel_reads.push_back('0);
            end
            OP_PIXEL:  n = paint_clipped_box(x, x, y, y, c);
            OP_HSPAN:  n = paint_clipped_box(x, xe, y, y, c);
            OP_VSPAN:  n = paint_clipped_box(x, x, y, ye, c);
            OP_RECT: begin
                // Edges may overlap at the corners; the engine draws each edge in full
                n = paint_clipped_box(x, x + w, y, y, c);
                n += paint_clipped_box(x, x + w, y + h, y + h, c);
                n += paint_clipped_box(x, x, y, y + h, c);
                n += paint_clipped_box(x + w, x + w, y, y + h, c);
            end
            OP_FILL_RECT:   n = paint_clipped_box(x, x + w, y, y + h, c);
            OP_FILL_SCREEN: n = paint_clipped_box(0, SCR_W - 1, 0, SCR_H - 1, c);
            default: ;
        endcase
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Command channel driver
    // ------------------------------------------------------------------

    // Send one command transaction. Enter and leave on a falling edge; hold
    // tvalid high between back-to-back transactions so it is never toggled
    // twice within one time step.
    task automatic issue_command(input logic [OPCODE_W-1:0] op, input int x, input int y,
                                 input int xe, input int ye, input int w, input int h,
                                 input logic [COLOR_W-1:0] c);
        int gaps;
        int pixels;
        gaps = 0;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            gaps++;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, COLOR_W'(c), EXTENT_W'(h), EXTENT_W'(w),
                     COORD_IN_W'(ye), COORD_IN_W'(xe), COORD_IN_W'(y), COORD_IN_W'(x)};
        do
            @(posedge aclk);
        while (!s_tready);
        // Transaction accepted at this edge: update the model straight away
        pixels = apply_command(op, x, y, xe, ye, w, h, c);
        pixels_modelled += pixels;
        if (op != OP_UNUSED) cmds_accepted++;
        // Extend the watchdog by a generous multiple of what this command costs
        watchdog_limit += 4 * (pixels + 16) + gaps;
        @(negedge aclk);
    endtask

    // Randomise result channel back-pressure on every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker: compare each read transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixel_reads.size() == 0) begin
                $error("pixel_value: no read outstanding, expected nothing, got %h", m_tdata);
                mismatches++;
            end else begin
                expected_value = pending_pixel_reads.pop_front();
                reads_checked++;
                if (m_tdata !== expected_value) begin
                    $error("pixel_value: expected %h, got %h", expected_value, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: the limit grows with every accepted command, so a hang trips it.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > watchdog_limit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Coordinate around the screen, with a margin either side of 0..extent-1.
    function automatic int near_coord(int extent);
        int v;
        v = $urandom_range(0, extent + 79);
        return v - 40;
    endfunction

    function automatic int any_coord();
        int v;
        v = $urandom_range(0, 4095);
        return v - 2048;
    endfunction

    // Pull a coordinate back onto the screen.
    function automatic int pin(int v, int extent);
        return (v < 0) ? 0 : ((v >= extent) ? extent - 1 : v);
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Store must read back as zero after the clearing pass.
    task automatic test_cleared_store();
        issue_command(OP_READ, 0, 0, 0, 0, 0, 0, '0);
        issue_command(OP_READ, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0, '0);
    endtask

    // Fill everything, read the centre, then probe just past the right and bottom edges: those read zero.
    task automatic test_fill_screen();
        issue_command(OP_FILL_SCREEN, 0, 0, 0, 0, 0, 0, 16'hffff);
        issue_command(OP_READ, SCR_W / 2, SCR_H / 2, 0, 0, 0, 0, '0);
        issue_command(OP_READ, SCR_W, 0, 0, 0, 0, 0, '0);
        issue_command(OP_READ, 0, SCR_H, 0, 0, 0, 0, '0);
    endtask

    // Corner pixels land; a pixel just right of the screen must not wrap into the next row.
    task automatic test_pixel_clipping();
        issue_command(OP_PIXEL, 0, 0, 0, 0, 0, 0, 16'h0001);
        issue_command(OP_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0, 16'h8000);
        issue_command(OP_PIXEL, SCR_W, 10, 0, 0, 0, 0, 16'h1234);
        issue_command(OP_PIXEL, -2048, -2048, 0, 0, 0, 0, 16'h4321);
        issue_command(OP_READ, 0, 0, 0, 0, 0, 0, '0);
        issue_command(OP_READ, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0, '0);
        issue_command(OP_READ, 0, 11, 0, 0, 0, 0, '0);
    endtask

    // Spans hanging off both ends are trimmed; a reversed span draws nothing.
    task automatic test_spans();
        issue_command(OP_HSPAN, -5, 5, 2047, 0, 0, 0, 16'h5555);
        issue_command(OP_HSPAN, 10, 6, 5, 0, 0, 0, 16'haaaa);
        issue_command(OP_VSPAN, 7, -2048, 0, 2047, 0, 0, 16'h0f0f);
        issue_command(OP_READ, SCR_W - 1, 5, 0, 0, 0, 0, '0);
        issue_command(OP_READ, 10, 6, 0, 0, 0, 0, '0);
        issue_command(OP_READ, 7, SCR_H - 1, 0, 0, 0, 0, '0);
    endtask

    // Outline with maximum extents near the bottom right corner, a one-pixel filled
    // rectangle, and an unused opcode with every field at an extreme.
    task automatic test_rectangles();
        issue_command(OP_RECT, 300, 230, 0, 0, 2047, 2047, 16'h07e0);
        issue_command(OP_FILL_RECT, 2, 2, 0, 0, 0, 0, 16'hf800);
        issue_command(OP_UNUSED, 2047, -2048, 2047, -2048, 2047, 2047, 16'hffff);
        issue_command(OP_READ, 310, 230, 0, 0, 0, 0, '0);
        issue_command(OP_READ, 300, SCR_H - 1, 0, 0, 0, 0, '0);
        issue_command(OP_READ, 301, 231, 0, 0, 0, 0, '0);
        issue_command(OP_READ, 2, 2, 0, 0, 0, 0, '0);
    endtask

    // ------------------------------------------------------------------
    // Random mix: mostly cheap, near-screen commands with read-back, a few
    // full-range fields placed so the clipped area stays small.
    // ------------------------------------------------------------------
    task automatic test_random_mix(input int n_cmds);
        int stop_at;
        int kind;
        int sub;
        int x, y, xe, ye, w, h;
        int ax, ay;
        logic [COLOR_W-1:0] c;
        stop_at = cmds_accepted + n_cmds;
        while (cmds_accepted < stop_at) begin
            // Fields an opcode ignores still carry random full-range values
            x  = any_coord();
            y  = any_coord();
            xe = any_coord();
            ye = any_coord();
            w  = $urandom_range(0, 2047);
            h  = $urandom_range(0, 2047);
            c  = $urandom_range(0, 65535);
            kind = $urandom_range(0, 99);
            sub  = $urandom_range(0, 99);
            if (kind < 30) begin
                // Read near the last drawing, anywhere on screen, or anywhere at all
                if (sub < 50) begin
                    x = last_x + $urandom_range(0, 6) - 3;
                    y = last_y + $urandom_range(0, 6) - 3;
                end else if (sub < 85) begin
                    x = $urandom_range(0, SCR_W - 1);
                    y = $urandom_range(0, SCR_H - 1);
                end
                issue_command(OP_READ, x, y, xe, ye, w, h, c);
            end else if (kind < 40) begin
                if (sub < 80) begin
                    x = near_coord(SCR_W);
                    y = near_coord(SCR_H);
                end
                last_x = pin(x, SCR_W);
                last_y = pin(y, SCR_H);
                issue_command(OP_PIXEL, x, y, xe, ye, w, h, c);
            end else if (kind < 52) begin
                x = near_coord(SCR_W);
                y = near_coord(SCR_H);
                if (sub < 80) xe = x + $urandom_range(0, 320) - 20;
                last_x = pin(x, SCR_W);
                last_y = pin(y, SCR_H);
                issue_command(OP_HSPAN, x, y, xe, ye, w, h, c);
            end else if (kind < 64) begin
                x = near_coord(SCR_W);
                y = near_coord(SCR_H);
                if (sub < 80) ye = y + $urandom_range(0, 240) - 20;
                last_x = pin(x, SCR_W);
                last_y = pin(y, SCR_H);
                issue_command(OP_VSPAN, x, y, xe, ye, w, h, c);
            end else if (kind < 76) begin
                x = near_coord(SCR_W);
                y = near_coord(SCR_H);
                if (sub < 70) begin
                    w = $urandom_range(0, 40);
                    h = $urandom_range(0, 40);
                end
                last_x = pin(x, SCR_W);
                last_y = pin(y, SCR_H);
                issue_command(OP_RECT, x, y, xe, ye, w, h, c);
            end else if (kind < 90) begin
                if (sub < 70) begin
                    x = near_coord(SCR_W);
                    y = near_coord(SCR_H);
                    w = $urandom_range(0, 15);
                    h = $urandom_range(0, 15);
                end else if (sub < 90) begin
                    // Large extents anchored far left and above: only a corner shows
                    x = $urandom_range(0, 15) - w;
                    y = $urandom_range(0, 15) - h;
                end else begin
                    x = near_coord(SCR_W);
                    y = near_coord(SCR_H);
                    h = $urandom_range(0, 15);
                end
                last_x = pin(x + w, SCR_W);
                last_y = pin(y + h, SCR_H);
                issue_command(OP_FILL_RECT, x, y, xe, ye, w, h, c);
            end else if (kind < 98) begin
                // Draw at an on-screen anchor, then read the anchor and a neighbour back
                ax = $urandom_range(0, SCR_W - 1);
                ay = $urandom_range(0, SCR_H - 1);
                if (sub < 25)
                    issue_command(OP_PIXEL, ax, ay, xe, ye, w, h, c);
                else if (sub < 50)
                    issue_command(OP_HSPAN, ax, ay, ax + $urandom_range(0, 40), ye, w, h, c);
                else if (sub < 75)
                    issue_command(OP_VSPAN, ax, ay, xe, ay + $urandom_range(0, 40), w, h, c);
                else
                    issue_command(OP_FILL_RECT, ax, ay, xe, ye,
                                  $urandom_range(0, 7), $urandom_range(0, 7), c);
                issue_command(OP_READ, ax, ay, xe, ye, w, h, c);
                issue_command(OP_READ, ax + $urandom_range(0, 2) - 1,
                              ay + $urandom_range(0, 2) - 1, xe, ye, w, h, c);
                last_x = ax;
                last_y = ay;
            end else if (kind < 99) begin
                issue_command(OP_UNUSED, x, y, xe, ye, w, h, c);
            end else if (fills_left > 0) begin
                // Whole-screen fills are expensive: allow only a few
                fills_left--;
                issue_command(OP_FILL_SCREEN, x, y, xe, ye, w, h, c);
            end else begin
                issue_command(OP_READ, x, y, xe, ye, w, h, c);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cmds_accepted   = 0;
        reads_checked   = 0;
        mismatches      = 0;
        pixels_modelled = 0;
        cycle_count     = 0;
        last_x          = 0;
        last_y          = 0;
        fills_left      = 3;
        // Cover reset plus the clearing pass several times over
        watchdog_limit  = 4 * (SCR_W * SCR_H + 16) + 2000;
        send_gap_pct    = 38;
        recv_stall_pct  = 57;
        for (int i = 0; i < SCR_W * SCR_H; i++) frame_model[i] = '0;

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_cleared_store();
        test_fill_screen();
        test_pixel_clipping();
        test_spans();
        test_rectangles();
        test_random_mix(342);

        // Swap the pacing: the sender now idles more than the receiver stalls
        send_gap_pct   = 57;
        recv_stall_pct = 38;
        test_random_mix(342);

        // Full rate on both sides
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_mix(342);

        s_tvalid <= 1'b0;
        // Drain outstanding reads, then let the pipeline settle
        while (pending_pixel_reads.size() != 0) @(posedge aclk);
        repeat (4 * READ_LATENCY) @(posedge aclk);

        $display("Covered %0d commands and %0d read-backs, %0d modelled pixel writes,",
                 cmds_accepted, reads_checked, pixels_modelled);
        $display("with clipping edges, reversed spans and three handshake pacing phases.");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/crlfe_pkg.sv
sv/crlfe_ram.sv
sv/crlfe_dp.sv
sv/clipped_rect_line_fill_engine_top.sv
dv/clipped_rect_line_fill_engine_top_tb.sv
